[hdl/ghtbp_pkg.sv]
// Shared types, sizes and function codes for the global history branch predictor.
// No dependencies; every other file imports this package.
package ghtbp_pkg;

    // Sizes of the predictor
    localparam int THREADS       = 2;
    localparam int HISTORY_BITS  = 4;
    localparam int TABLE_ENTRIES = 1024;
    localparam int COUNTER_BITS  = 2;
    localparam int PC_SHIFT      = 2;

    // Fixed field widths of the item ports
    localparam int FUNC_W   = 3;
    localparam int THREAD_W = 1;
    localparam int PC_W     = 32;
    localparam int SNAP_W   = 4;

    // Derived sizes
    localparam int ROW_BITS  = $clog2(TABLE_ENTRIES);
    localparam int ADDR_BITS = THREAD_W + HISTORY_BITS + ROW_BITS;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNCOND   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BTB_MISS = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RESTORE  = 3'd4;

    typedef logic [HISTORY_BITS-1:0] t_hist;
    typedef logic [COUNTER_BITS-1:0] t_ctr;
    typedef logic [ROW_BITS-1:0]     t_row;
    typedef logic [ADDR_BITS-1:0]    t_addr;

    localparam t_ctr CTR_MAX = '1;

    // Decoded item handed from front to back
    typedef struct packed {
        logic                is_lookup;
        logic                is_uncond;
        logic                is_btb_miss;
        logic                is_update;
        logic                is_restore;
        logic                thr_ok;
        logic [THREAD_W-1:0] thread;
        t_row                row;
        logic                taken;
        logic                squashed;
        logic                snap_valid;
        t_hist               snap;
    } t_item;

    // Status from back to front
    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

[hdl/ghtbp_front.sv]
// Front end: accepts input transfers, decodes the function and pc row, holds one item.
// Depends on ghtbp_pkg.
module ghtbp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ghtbp_pkg::FUNC_W-1:0]    i_func,
    input  logic [ghtbp_pkg::THREAD_W-1:0]  i_thread,
    input  logic [ghtbp_pkg::PC_W-1:0]      i_pc,
    input  logic                            i_taken,
    input  logic                            i_squashed,
    input  logic                            i_snapshot_valid,
    input  logic [ghtbp_pkg::SNAP_W-1:0]    i_history_snapshot,
    input  ghtbp_pkg::t_back_status         i_status,
    output logic                            o_item_valid,
    output ghtbp_pkg::t_item                o_item,
    input  logic                            i_item_ready
);
    import ghtbp_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    // Hold off input while the counter table is being cleared
    assign o_ready = !i_status.clearing && (!r_valid || i_item_ready);
    assign accept  = i_valid && o_ready;

    // Decode
    always_comb begin
        n_item             = '0;
        n_item.is_lookup   = (i_func == FUNC_LOOKUP);
        n_item.is_uncond   = (i_func == FUNC_UNCOND);
        n_item.is_btb_miss = (i_func == FUNC_BTB_MISS);
        n_item.is_update   = (i_func == FUNC_UPDATE);
        n_item.is_restore  = (i_func == FUNC_RESTORE);
        n_item.thr_ok      = (int'(i_thread) < THREADS);
        n_item.thread      = i_thread;
        n_item.row         = i_pc[PC_SHIFT +: ROW_BITS];
        n_item.taken       = i_taken;
        n_item.squashed    = i_squashed;
        n_item.snap_valid  = i_snapshot_valid;
        n_item.snap        = i_history_snapshot[HISTORY_BITS-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

[hdl/ghtbp_queue.sv]
// Two-entry queue of decoded items between front and back.
// Depends on ghtbp_pkg.
module ghtbp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ghtbp_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output ghtbp_pkg::t_item o_item
);
    import ghtbp_pkg::*;

    t_item      r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_slot[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/ghtbp_back.sv]
// Back end: history registers, counter table memory, and the result register.
// Depends on ghtbp_pkg.
module ghtbp_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    input  ghtbp_pkg::t_item                i_item,
    output logic                            o_pop,
    output ghtbp_pkg::t_back_status         o_status,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_prediction,
    output logic [ghtbp_pkg::SNAP_W-1:0]    o_history_out
);
    import ghtbp_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_addr      r_clr_addr;
    t_hist      r_hist [THREADS];
    t_ctr       r_mem [2**ADDR_BITS];
    t_ctr       r_rdata;
    t_item      r_cur;
    t_hist      r_cur_hist;
    t_addr      r_addr;
    logic       r_out_valid;
    logic       r_pred;
    t_hist      r_hist_out;

    t_hist      head_hist;
    t_hist      idx_hist;
    t_addr      rd_addr;
    logic       issue;
    logic       exec_done;
    logic       out_free;
    logic       n_pred;
    t_hist      n_hist;
    logic       hist_we;
    t_ctr       n_ctr;
    logic       mem_we;
    t_addr      mem_addr;
    t_ctr       mem_wdata;

    assign o_status.clearing = (r_state == S_CLEAR);

    // Issue: pop the queue head and read its counter
    assign head_hist = r_hist[i_item.thread];
    assign idx_hist  = i_item.is_update ? i_item.snap : head_hist;
    assign rd_addr   = {i_item.thread, idx_hist, i_item.row};
    assign issue     = (r_state == S_IDLE) && !i_empty;
    assign o_pop     = issue;

    assign out_free  = !r_out_valid || i_ready;
    assign exec_done = (r_state == S_EXEC) && out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (issue) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Execute: prediction, history change, counter update
    always_comb begin
        n_pred  = 1'b0;
        n_hist  = r_cur_hist;
        hist_we = 1'b0;
        n_ctr   = r_rdata;
        if (r_cur.taken) begin
            if (r_rdata != CTR_MAX) begin
                n_ctr = r_rdata + t_ctr'(1);
            end
        end else begin
            if (r_rdata != '0) begin
                n_ctr = r_rdata - t_ctr'(1);
            end
        end
        if (r_cur.thr_ok) begin
            if (r_cur.is_lookup) begin
                n_pred  = r_rdata[COUNTER_BITS-1];
                n_hist  = t_hist'({r_cur_hist, r_rdata[COUNTER_BITS-1]});
                hist_we = 1'b1;
            end else if (r_cur.is_uncond) begin
                n_pred  = 1'b1;
                n_hist  = t_hist'({r_cur_hist, 1'b1});
                hist_we = 1'b1;
            end else if (r_cur.is_btb_miss) begin
                n_hist  = r_cur_hist & ~t_hist'(1);
                hist_we = 1'b1;
            end else if (r_cur.is_update) begin
                if (r_cur.snap_valid && r_cur.squashed) begin
                    n_hist  = t_hist'({r_cur.snap, r_cur.taken});
                    hist_we = 1'b1;
                end
            end else if (r_cur.is_restore) begin
                n_hist  = r_cur.snap;
                hist_we = 1'b1;
            end
        end
    end

    // Memory write port: clearing sweep or counter update
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = exec_done && r_cur.thr_ok && r_cur.is_update && r_cur.snap_valid;
            mem_addr  = r_addr;
            mem_wdata = n_ctr;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < THREADS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
            end
            if (exec_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (exec_done && hist_we) begin
                r_hist[r_cur.thread] <= n_hist;
            end
        end
    end

    // Counter table
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Item in execution and result payload
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cur      <= i_item;
            r_cur_hist <= head_hist;
            r_addr     <= rd_addr;
        end
        if (exec_done) begin
            r_pred     <= n_pred;
            r_hist_out <= r_cur.thr_ok ? r_cur_hist : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_prediction  = r_pred;
    assign o_history_out = SNAP_W'(r_hist_out);

endmodule

[hdl/global_history_table_branch_predictor_top.sv]
// Top level of the global history branch predictor: front end, item queue, back end.
// Depends on ghtbp_pkg, ghtbp_front, ghtbp_queue and ghtbp_back.
//
//   channel  handshake          payload
//   input    i_valid / o_ready  i_func i_thread i_pc i_taken i_squashed
//                               i_snapshot_valid i_history_snapshot
//   output   o_valid / i_ready  o_prediction o_history_out
//
// Each item passes through the front register and then the back end (counter table
// read, then execute); the back end takes a new item only once the last one has
// executed, as the single-port read-modify-write of the counter table requires.
// After reset the back end zeroes the counter table one entry a cycle, all
// 2**ADDR_BITS (32768) entries, with o_ready low. A stalled output holds the back
// end in execute; the queue and front register keep taking items until full.
module global_history_table_branch_predictor_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [ghtbp_pkg::FUNC_W-1:0]    i_func,
    input  logic [ghtbp_pkg::THREAD_W-1:0]  i_thread,
    input  logic [ghtbp_pkg::PC_W-1:0]      i_pc,
    input  logic                            i_taken,
    input  logic                            i_squashed,
    input  logic                            i_snapshot_valid,
    input  logic [ghtbp_pkg::SNAP_W-1:0]    i_history_snapshot,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_prediction,
    output logic [ghtbp_pkg::SNAP_W-1:0]    o_history_out
);
    import ghtbp_pkg::*;

    t_back_status status;
    logic         fr_valid;
    t_item        fr_item;
    logic         q_full;
    logic         q_empty;
    logic         q_pop;
    t_item        q_item;
    logic         q_push;

    assign q_push = fr_valid && !q_full;

    ghtbp_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_thread           (i_thread),
        .i_pc               (i_pc),
        .i_taken            (i_taken),
        .i_squashed         (i_squashed),
        .i_snapshot_valid   (i_snapshot_valid),
        .i_history_snapshot (i_history_snapshot),
        .i_status           (status),
        .o_item_valid       (fr_valid),
        .o_item             (fr_item),
        .i_item_ready       (!q_full)
    );

    ghtbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    ghtbp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_item        (q_item),
        .o_pop         (q_pop),
        .o_status      (status),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_prediction  (o_prediction),
        .o_history_out (o_history_out)
    );

endmodule
